// ----- rtl/rms_pkg.sv -----
// Package: shared types, codes and constants of the ride motion state machine.
`timescale 1ns / 1ps

package rms_pkg;

    // Event kinds
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // Ride states
    localparam logic [1:0] ST_SLEEP     = 2'd0;
    localparam logic [1:0] ST_AWAKE     = 2'd1;
    localparam logic [1:0] ST_RECORDING = 2'd2;
    localparam logic [1:0] ST_WAITING   = 2'd3;

    // Action codes
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_RESUME = 3'd2;
    localparam logic [2:0] ACT_PAUSE  = 3'd3;
    localparam logic [2:0] ACT_END    = 3'd4;

    // Configuration register indexes
    localparam logic [7:0] REG_START_SPEED   = 8'd0;
    localparam logic [7:0] REG_STOP_SPEED    = 8'd1;
    localparam logic [7:0] REG_GYRO_THRESH   = 8'd2;
    localparam logic [7:0] REG_ACCEL_THRESH  = 8'd3;
    localparam logic [7:0] REG_START_HOLD    = 8'd4;
    localparam logic [7:0] REG_SLEEP_TIMEOUT = 8'd5;
    localparam logic [7:0] REG_PAUSE_AFTER   = 8'd6;
    localparam logic [7:0] REG_WAIT_TIMEOUT  = 8'd7;

    // Register reset values
    localparam logic [15:0] RST_START_SPEED   = 16'd512;
    localparam logic [15:0] RST_STOP_SPEED    = 16'd256;
    localparam logic [15:0] RST_GYRO_THRESH   = 16'd512;
    localparam logic [15:0] RST_ACCEL_THRESH  = 16'd1024;
    localparam logic [23:0] RST_START_HOLD    = 24'd3000;
    localparam logic [23:0] RST_SLEEP_TIMEOUT = 24'd60000;
    localparam logic [23:0] RST_PAUSE_AFTER   = 24'd5000;
    localparam logic [23:0] RST_WAIT_TIMEOUT  = 24'd300000;

    // Fixed behavior
    localparam logic        AUTO_START       = 1'b1;
    localparam logic [23:0] NO_GNSS_PAUSE_MS = 24'd10000;
    localparam logic [15:0] GRAVITY_Q10      = 16'd10042;

    // Configuration register file contents
    typedef struct packed {
        logic [15:0] start_speed;
        logic [15:0] stop_speed;
        logic [15:0] gyro_threshold;
        logic [15:0] accel_threshold;
        logic [23:0] start_hold_ms;
        logic [23:0] sleep_timeout_ms;
        logic [23:0] pause_after_ms;
        logic [23:0] wait_timeout_ms;
    } cfg_t;

    // One input event as held in the input register
    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        now_ms;
        logic               speed_valid;
        logic [15:0]        speed;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } evt_t;

    // Event after the squared-norm stage
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic        speed_valid;
        logic [15:0] speed;
        logic [31:0] gyro_sq;
        logic [31:0] accel_sq;
    } mot_t;

    // Squared IMU thresholds
    typedef struct packed {
        logic [31:0] gyro_sq;
        logic [33:0] accel_hi_sq;
        logic [27:0] accel_lo_sq;
        logic        accel_lo_en;
    } thr_t;

endpackage

// ----- rtl/rms_if.sv -----
// Interfaces: event input, result output and configuration write channels.
`timescale 1ns / 1ps

interface rms_evt_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [31:0]        now_ms;
    logic               speed_valid;
    logic [15:0]        speed;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (output valid, op, now_ms, speed_valid, speed, gyro_x, gyro_y, gyro_z,
                    accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, op, now_ms, speed_valid, speed, gyro_x, gyro_y, gyro_z,
                    accel_x, accel_y, accel_z, output ready);
endinterface

interface rms_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [1:0] ride_state_out;
    logic       moving_out;

    modport source (output valid, action, ride_state_out, moving_out, input ready);
    modport sink   (input valid, action, ride_state_out, moving_out, output ready);
endinterface

interface rms_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/rms_cfg.sv -----
// Configuration register file with write port.
`timescale 1ns / 1ps

module rms_cfg
    import rms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rms_cfg_if.sink   cfg,
    output cfg_t      regs
);

    cfg_t regs_reg;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.start_speed      <= RST_START_SPEED;
            regs_reg.stop_speed       <= RST_STOP_SPEED;
            regs_reg.gyro_threshold   <= RST_GYRO_THRESH;
            regs_reg.accel_threshold  <= RST_ACCEL_THRESH;
            regs_reg.start_hold_ms    <= RST_START_HOLD;
            regs_reg.sleep_timeout_ms <= RST_SLEEP_TIMEOUT;
            regs_reg.pause_after_ms   <= RST_PAUSE_AFTER;
            regs_reg.wait_timeout_ms  <= RST_WAIT_TIMEOUT;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_START_SPEED:   regs_reg.start_speed      <= cfg.data[15:0];
                REG_STOP_SPEED:    regs_reg.stop_speed       <= cfg.data[15:0];
                REG_GYRO_THRESH:   regs_reg.gyro_threshold   <= cfg.data[15:0];
                REG_ACCEL_THRESH:  regs_reg.accel_threshold  <= cfg.data[15:0];
                REG_START_HOLD:    regs_reg.start_hold_ms    <= cfg.data[23:0];
                REG_SLEEP_TIMEOUT: regs_reg.sleep_timeout_ms <= cfg.data[23:0];
                REG_PAUSE_AFTER:   regs_reg.pause_after_ms   <= cfg.data[23:0];
                REG_WAIT_TIMEOUT:  regs_reg.wait_timeout_ms  <= cfg.data[23:0];
                default:           ;
            endcase
        end
    end

endmodule

// ----- rtl/rms_motion.sv -----
// Squared-norm stage: gyro and accel squared norms, squared thresholds.
`timescale 1ns / 1ps

module rms_motion
    import rms_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t regs,
    input  logic in_valid,
    input  evt_t in_evt,
    input  logic out_en,
    output logic in_en,
    output logic out_valid,
    output mot_t out_mot,
    output thr_t thr
);

    logic               valid_reg;
    mot_t               mot_reg;
    thr_t               thr_reg;
    logic signed [31:0] gx_sq, gy_sq, gz_sq, ax_sq, ay_sq, az_sq;
    logic [16:0]        accel_hi;
    logic [15:0]        accel_lo;
    thr_t               thr_next;

    // Stage advances when empty or when downstream takes its item
    assign in_en     = !valid_reg || out_en;
    assign out_valid = valid_reg;
    assign out_mot   = mot_reg;
    assign thr       = thr_reg;

    // Per-axis squares; each sum of three fits in 32 bits unsigned
    assign gx_sq = in_evt.gyro_x * in_evt.gyro_x;
    assign gy_sq = in_evt.gyro_y * in_evt.gyro_y;
    assign gz_sq = in_evt.gyro_z * in_evt.gyro_z;
    assign ax_sq = in_evt.accel_x * in_evt.accel_x;
    assign ay_sq = in_evt.accel_y * in_evt.accel_y;
    assign az_sq = in_evt.accel_z * in_evt.accel_z;

    // Threshold squares around gravity, from config
    assign accel_hi = {1'b0, GRAVITY_Q10} + {1'b0, regs.accel_threshold};
    assign accel_lo = GRAVITY_Q10 - regs.accel_threshold;

    always_comb
    begin
        thr_next.gyro_sq     = {16'd0, regs.gyro_threshold} * {16'd0, regs.gyro_threshold};
        thr_next.accel_hi_sq = {17'd0, accel_hi} * {17'd0, accel_hi};
        thr_next.accel_lo_sq = {14'd0, accel_lo[13:0]} * {14'd0, accel_lo[13:0]};
        thr_next.accel_lo_en = regs.accel_threshold < GRAVITY_Q10;
    end

    // Threshold squares follow config in the next cycle
    always_ff @(posedge clk)
    begin
        thr_reg <= thr_next;
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (in_en && in_valid)
        begin
            mot_reg.op          <= in_evt.op;
            mot_reg.now_ms      <= in_evt.now_ms;
            mot_reg.speed_valid <= in_evt.speed_valid;
            mot_reg.speed       <= in_evt.speed;
            mot_reg.gyro_sq     <= $unsigned(gx_sq) + $unsigned(gy_sq) + $unsigned(gz_sq);
            mot_reg.accel_sq    <= $unsigned(ax_sq) + $unsigned(ay_sq) + $unsigned(az_sq);
        end
    end

endmodule

// ----- rtl/rms_fsm.sv -----
// Motion decision, qualification timers, ride state machine and result register.
`timescale 1ns / 1ps

module rms_fsm
    import rms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      regs,
    input  thr_t      thr,
    input  logic      in_valid,
    input  mot_t      in_mot,
    output logic      in_en,
    rms_res_if.source res
);

    // Ride state
    logic [1:0]  state_reg, state_next;
    logic [31:0] entered_reg, entered_next;
    logic        mv_seen_reg, mv_seen_next;
    logic [31:0] mv_start_reg, mv_start_next;
    logic        st_seen_reg, st_seen_next;
    logic [31:0] st_start_reg, st_start_next;
    logic        moving_reg, moving_next;
    logic        hold_reg, hold_next;

    // Result register
    logic        valid_reg;
    logic [2:0]  action_reg, action_next;
    logic [1:0]  res_state_reg;
    logic        res_moving_reg;

    logic        fire;
    logic        imu_moving, above, below;
    logic [31:0] moving_for, stopped_for, in_state_for;
    logic [23:0] pause_need;

    assign in_en = !valid_reg || res.ready;
    assign fire  = in_en && in_valid;

    assign res.valid          = valid_reg;
    assign res.action         = action_reg;
    assign res.ride_state_out = res_state_reg;
    assign res.moving_out     = res_moving_reg;

    // Motion decisions
    assign imu_moving = (in_mot.gyro_sq > thr.gyro_sq)
                     || ({2'b00, in_mot.accel_sq} > thr.accel_hi_sq)
                     || (thr.accel_lo_en && (in_mot.accel_sq < {4'd0, thr.accel_lo_sq}));
    assign above = in_mot.speed_valid ? (in_mot.speed >= regs.start_speed) : imu_moving;
    assign below = in_mot.speed_valid ? (in_mot.speed < regs.stop_speed) : !imu_moving;

    // Qualification times; zero on the first qualifying event
    assign moving_for   = (above && mv_seen_reg) ? (in_mot.now_ms - mv_start_reg) : 32'd0;
    assign stopped_for  = (below && st_seen_reg) ? (in_mot.now_ms - st_start_reg) : 32'd0;
    assign in_state_for = in_mot.now_ms - entered_reg;
    assign pause_need   = in_mot.speed_valid ? regs.pause_after_ms : NO_GNSS_PAUSE_MS;

    // Next state and action
    always_comb
    begin
        state_next    = state_reg;
        mv_seen_next  = mv_seen_reg;
        mv_start_next = mv_start_reg;
        st_seen_next  = st_seen_reg;
        st_start_next = st_start_reg;
        moving_next   = moving_reg;
        hold_next     = hold_reg;
        action_next   = ACT_NONE;

        unique case (in_mot.op)
            OP_UPDATE:
            begin
                moving_next   = above;
                mv_seen_next  = above;
                mv_start_next = (above && !mv_seen_reg) ? in_mot.now_ms : mv_start_reg;
                st_seen_next  = below;
                st_start_next = (below && !st_seen_reg) ? in_mot.now_ms : st_start_reg;

                unique case (state_reg)
                    ST_SLEEP:
                    begin
                        if (imu_moving || above)
                        begin
                            state_next = ST_AWAKE;
                        end
                    end
                    ST_AWAKE:
                    begin
                        priority if (AUTO_START && above
                                     && (moving_for >= {8'd0, regs.start_hold_ms}))
                        begin
                            state_next  = ST_RECORDING;
                            action_next = ACT_START;
                        end
                        else if (!imu_moving && !above
                                 && (in_state_for >= {8'd0, regs.sleep_timeout_ms}))
                        begin
                            state_next = ST_SLEEP;
                        end
                        else
                        begin
                            // stay awake
                            state_next = state_reg;
                        end
                    end
                    ST_RECORDING:
                    begin
                        if (!hold_reg && below && (stopped_for >= {8'd0, pause_need}))
                        begin
                            state_next  = ST_WAITING;
                            action_next = ACT_PAUSE;
                        end
                    end
                    ST_WAITING:
                    begin
                        priority if (above)
                        begin
                            state_next  = ST_RECORDING;
                            action_next = ACT_RESUME;
                        end
                        else if (in_state_for >= {8'd0, regs.wait_timeout_ms})
                        begin
                            state_next  = ST_AWAKE;
                            action_next = ACT_END;
                        end
                        else
                        begin
                            // keep waiting
                            state_next = state_reg;
                        end
                    end
                    default: ;
                endcase
            end
            OP_START:
            begin
                if (state_reg != ST_RECORDING)
                begin
                    hold_next   = 1'b1;
                    state_next  = ST_RECORDING;
                    action_next = (state_reg == ST_WAITING) ? ACT_RESUME : ACT_START;
                end
            end
            OP_STOP:
            begin
                if (state_reg == ST_RECORDING || state_reg == ST_WAITING)
                begin
                    hold_next   = 1'b0;
                    state_next  = ST_AWAKE;
                    action_next = ACT_END;
                end
            end
            OP_NOP: ;
            default: ;
        endcase

        // Entry time only moves on a real change of state
        entered_next = (state_next != state_reg) ? in_mot.now_ms : entered_reg;
    end

    // State and result update on each event transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SLEEP;
            entered_reg  <= 32'd0;
            mv_seen_reg  <= 1'b0;
            mv_start_reg <= 32'd0;
            st_seen_reg  <= 1'b0;
            st_start_reg <= 32'd0;
            moving_reg   <= 1'b0;
            hold_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_en)
            begin
                valid_reg <= in_valid;
            end
            if (fire)
            begin
                state_reg    <= state_next;
                entered_reg  <= entered_next;
                mv_seen_reg  <= mv_seen_next;
                mv_start_reg <= mv_start_next;
                st_seen_reg  <= st_seen_next;
                st_start_reg <= st_start_next;
                moving_reg   <= moving_next;
                hold_reg     <= hold_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            action_reg     <= action_next;
            res_state_reg  <= state_next;
            res_moving_reg <= moving_next;
        end
    end

endmodule

// ----- rtl/ride_motion_state_machine_top.sv -----
// Pipeline: an event transfer loads the input register, then the squared-norm
// and result registers follow; the result is valid once the result register is loaded.
// Throughput: one event per cycle; each pipeline register holds its item
// only while the next stage is full and stalled.
// Reset: rst_n clears the pipeline valids, the ride state (sleep) and timers,
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps

module ride_motion_state_machine_top
    import rms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rms_evt_if.sink   evt,
    rms_res_if.source res,
    rms_cfg_if.sink   cfg
);

    cfg_t regs;
    thr_t thr;
    logic s1_valid_reg;
    evt_t s1_evt_reg;
    logic s1_en, s2_en, s3_en;
    logic s2_valid;
    mot_t s2_mot;

    // Input register advances when empty or when stage 2 takes its item
    assign s1_en     = !s1_valid_reg || s2_en;
    assign evt.ready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && evt.valid)
        begin
            s1_evt_reg.op          <= evt.op;
            s1_evt_reg.now_ms      <= evt.now_ms;
            s1_evt_reg.speed_valid <= evt.speed_valid;
            s1_evt_reg.speed       <= evt.speed;
            s1_evt_reg.gyro_x      <= evt.gyro_x;
            s1_evt_reg.gyro_y      <= evt.gyro_y;
            s1_evt_reg.gyro_z      <= evt.gyro_z;
            s1_evt_reg.accel_x     <= evt.accel_x;
            s1_evt_reg.accel_y     <= evt.accel_y;
            s1_evt_reg.accel_z     <= evt.accel_z;
        end
    end

    // Configuration registers
    rms_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Squared norms
    rms_motion u_motion (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .in_valid  (s1_valid_reg),
        .in_evt    (s1_evt_reg),
        .out_en    (s3_en),
        .in_en     (s2_en),
        .out_valid (s2_valid),
        .out_mot   (s2_mot),
        .thr       (thr)
    );

    // State machine and result register
    rms_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .regs     (regs),
        .thr      (thr),
        .in_valid (s2_valid),
        .in_mot   (s2_mot),
        .in_en    (s3_en),
        .res      (res)
    );

endmodule

// ----- rtl/rms_checker.sv -----
// Port-level checker for the ride motion state machine, bound to the top level.
`timescale 1ns / 1ps

module rms_checker
    import rms_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] action,
    input logic [1:0] ride_state_out
);

    // A stalled result holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(action)
                                    && $stable(ride_state_out))
        else $error("result changed while stalled");

    // Start and resume always land in recording
    a_start_rec: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (action == ACT_START || action == ACT_RESUME)
            |-> ride_state_out == ST_RECORDING)
        else $error("start or resume without recording state");

    // Pause always lands in waiting
    a_pause_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && action == ACT_PAUSE |-> ride_state_out == ST_WAITING)
        else $error("pause without waiting state");

    // End of ride always lands in awake
    a_end_awake: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && action == ACT_END |-> ride_state_out == ST_AWAKE)
        else $error("end without awake state");

endmodule

bind ride_motion_state_machine_top rms_checker u_rms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .action         (res.action),
    .ride_state_out (res.ride_state_out)
);
